// ----- sv/slsc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the staircase light sequencer
package slsc_pkg;

	// field widths
	localparam int unsigned CHAN_W  = 7;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// saturation value of the elapsed counters
	localparam logic [TICK_W-1:0] TICK_SAT = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_IN_USE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REARM_TICKS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_PACE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_PACE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL        = 3'd5;

	// configuration reset values
	localparam logic [CHAN_W-1:0]  RST_STEPS_IN_USE = 7'd16;
	localparam logic [TICK_W-1:0]  RST_REARM_TICKS  = 16'd500;
	localparam logic [TICK_W-1:0]  RST_HOLD_TICKS   = 16'd10000;
	localparam logic [TICK_W-1:0]  RST_LIGHT_PACE   = 16'd500;
	localparam logic [TICK_W-1:0]  RST_CLEAR_PACE   = 16'd150;
	localparam logic [LEVEL_W-1:0] RST_ON_LEVEL     = 8'd255;

	// one tick request: two sensor levels
	typedef struct packed {
		logic top_sensor;
		logic bottom_sensor;
	} slsc_in_t;

	// one channel write
	typedef struct packed {
		logic [CHAN_W-1:0]  channel;
		logic [LEVEL_W-1:0] level;
	} slsc_out_t;

	// configuration register contents
	typedef struct packed {
		logic [CHAN_W-1:0]  steps_in_use;
		logic [TICK_W-1:0]  rearm_ticks;
		logic [TICK_W-1:0]  hold_ticks;
		logic [TICK_W-1:0]  light_pace_ticks;
		logic [TICK_W-1:0]  clear_pace_ticks;
		logic [LEVEL_W-1:0] on_level;
	} slsc_cfg_t;

endpackage

// ----- sv/slsc_cfg_regs.sv -----
`timescale 1ns / 1ps
// configuration register file of the staircase light sequencer
module slsc_cfg_regs
	import slsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output slsc_cfg_t             cfg
);

	slsc_cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steps_in_use     <= RST_STEPS_IN_USE;
			cfg_q.rearm_ticks      <= RST_REARM_TICKS;
			cfg_q.hold_ticks       <= RST_HOLD_TICKS;
			cfg_q.light_pace_ticks <= RST_LIGHT_PACE;
			cfg_q.clear_pace_ticks <= RST_CLEAR_PACE;
			cfg_q.on_level         <= RST_ON_LEVEL;
		end else if (wr_en) begin
			case (wr_index)
				REG_STEPS_IN_USE: cfg_q.steps_in_use     <= wr_data[CHAN_W-1:0];
				REG_REARM_TICKS:  cfg_q.rearm_ticks      <= wr_data[TICK_W-1:0];
				REG_HOLD_TICKS:   cfg_q.hold_ticks       <= wr_data[TICK_W-1:0];
				REG_LIGHT_PACE:   cfg_q.light_pace_ticks <= wr_data[TICK_W-1:0];
				REG_CLEAR_PACE:   cfg_q.clear_pace_ticks <= wr_data[TICK_W-1:0];
				REG_ON_LEVEL:     cfg_q.on_level         <= wr_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/slsc_seq.sv -----
`timescale 1ns / 1ps
// phase, step indexes and elapsed counters with the per-tick update
module slsc_seq
	import slsc_pkg::*;
#(
	parameter int unsigned MAX_STEPS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  slsc_in_t  sensors,
	input  slsc_cfg_t cfg,
	output logic      res_valid,
	output slsc_out_t res_data
);

	// largest step count reachable through the 7-bit register
	localparam int unsigned NMAX  = (MAX_STEPS < 127) ? MAX_STEPS : 127;
	localparam int unsigned IDX_W = $clog2(NMAX + 2);
	localparam int unsigned RST_N = (NMAX < 16) ? NMAX : 16;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_LIGHT_UP   = 3'd1,
		PH_LIGHT_DOWN = 3'd2,
		PH_CLEAR_UP   = 3'd3,
		PH_CLEAR_DOWN = 3'd4
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [IDX_W-1:0]  up_q, up_d, down_q, down_d;
	logic [TICK_W-1:0] trig_q, trig_d, step_q, step_d, hold_q, hold_d;
	logic [IDX_W-1:0]  n_steps;
	logic              blocked, wrote, emit_en;
	logic [IDX_W-1:0]  emit_idx;
	logic [LEVEL_W-1:0] emit_level;

	// step count clamped to 1..NMAX
	always_comb begin
		if (cfg.steps_in_use == '0) begin
			n_steps = IDX_W'(1);
		end else if (int'(cfg.steps_in_use) > int'(NMAX)) begin
			n_steps = IDX_W'(NMAX);
		end else begin
			n_steps = IDX_W'(cfg.steps_in_use);
		end
	end

	// one tick: counters, sensors, lighting, hold check, clearing
	always_comb begin
		phase_d    = phase_q;
		up_d       = up_q;
		down_d     = down_q;
		trig_d     = (trig_q == TICK_SAT) ? trig_q : trig_q + 1'b1;
		step_d     = (step_q == TICK_SAT) ? step_q : step_q + 1'b1;
		hold_d     = (hold_q == TICK_SAT) ? hold_q : hold_q + 1'b1;
		blocked    = 1'b0;
		wrote      = 1'b0;
		emit_en    = 1'b0;
		emit_idx   = up_q;
		emit_level = cfg.on_level;

		// top trigger has priority, a rejected one masks the bottom sensor
		if (sensors.top_sensor) begin
			if (trig_d < cfg.rearm_ticks) begin
				blocked = 1'b1;
			end else begin
				trig_d = '0;
				hold_d = '0;
				if (phase_d != PH_LIGHT_DOWN) phase_d = PH_LIGHT_UP;
			end
		end
		if (!blocked && sensors.bottom_sensor && trig_d >= cfg.rearm_ticks) begin
			trig_d = '0;
			hold_d = '0;
			if (phase_d != PH_LIGHT_UP) phase_d = PH_LIGHT_DOWN;
		end

		// lighting
		if (phase_d == PH_LIGHT_UP && up_d <= n_steps && step_d >= cfg.light_pace_ticks) begin
			emit_en    = 1'b1;
			emit_idx   = up_d;
			emit_level = cfg.on_level;
			wrote      = 1'b1;
			step_d     = '0;
			up_d       = up_d + 1'b1;
			if (up_d > n_steps) hold_d = '0;
		end else if (phase_d == PH_LIGHT_DOWN && down_d != '0
				&& step_d >= cfg.light_pace_ticks) begin
			emit_en    = 1'b1;
			emit_idx   = down_d;
			emit_level = cfg.on_level;
			wrote      = 1'b1;
			step_d     = '0;
			down_d     = down_d - 1'b1;
			if (down_d == '0) hold_d = '0;
		end

		// hold expiry
		if (phase_d == PH_LIGHT_UP && up_d > n_steps) begin
			if (hold_d >= cfg.hold_ticks) phase_d = PH_CLEAR_UP;
		end else if (phase_d == PH_LIGHT_DOWN && down_d == '0) begin
			if (hold_d >= cfg.hold_ticks) phase_d = PH_CLEAR_DOWN;
		end

		// clearing, only in a tick without a lighting write
		if (!wrote && step_d >= cfg.clear_pace_ticks) begin
			case (phase_d)
				PH_CLEAR_UP: begin
					emit_en    = 1'b1;
					emit_idx   = up_d;
					emit_level = '0;
					if (up_d != '0) up_d = up_d - 1'b1;
					step_d = '0;
					if (up_d == '0) begin
						phase_d = PH_IDLE;
						up_d    = IDX_W'(1);
					end
				end
				PH_CLEAR_DOWN: begin
					emit_en    = 1'b1;
					emit_idx   = down_d;
					emit_level = '0;
					down_d     = down_d + 1'b1;
					step_d     = '0;
					if (down_d > n_steps) begin
						phase_d = PH_IDLE;
						down_d  = n_steps;
					end
				end
				default: ;
			endcase
		end
	end

	// writes outside 1..N are dropped
	assign res_valid        = emit_en && emit_idx != '0 && emit_idx <= n_steps;
	assign res_data.channel = CHAN_W'(emit_idx);
	assign res_data.level   = emit_level;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			up_q    <= IDX_W'(1);
			down_q  <= IDX_W'(RST_N);
			trig_q  <= '0;
			step_q  <= '0;
			hold_q  <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			up_q    <= up_d;
			down_q  <= down_d;
			trig_q  <= trig_d;
			step_q  <= step_d;
			hold_q  <= hold_d;
		end
	end

endmodule

// ----- sv/staircase_light_sequencer_core.sv -----
`timescale 1ns / 1ps
// staircase light sequencer top level: input stage, sequencer, result register
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, in_data          | tick request in
//  out     | out_valid, out_ready, out_data       | channel write out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write in
//
// A tick request is taken into the input stage and evaluated there; its
// channel write, if any, then enters the result register, which drives out_valid.
// One request per cycle is sustained while no write stalls in the input stage;
// the state update is computed combinationally from the input stage.
// A request stalls in the input stage only while it has a write to deliver
// and the result register is still full; ticks without a write never wait.
// Reset is asynchronous and puts the sequencer idle with default registers.
module staircase_light_sequencer_core
	import slsc_pkg::*;
#(
	parameter int unsigned MAX_STEPS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  slsc_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output slsc_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	slsc_cfg_t cfg;
	logic      valid_s1;
	slsc_in_t  data_s1;
	logic      res_valid;
	slsc_out_t res_data;
	logic      advance;
	logic      out_valid_q;
	slsc_out_t out_data_q;

	assign cfg_ready = 1'b1;

	slsc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	slsc_seq #(
		.MAX_STEPS (MAX_STEPS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.sensors   (data_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	// stage 1 moves on unless its write meets a full result register
	assign advance  = valid_s1 && (!res_valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) data_s1 <= in_data;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) out_data_q <= res_data;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a produced write always lands in the result register
	a_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid |=> out_valid_q)
		else $error("channel write lost");

	// a write blocked by a full result register keeps its request in stage 1
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid && out_valid_q && !out_ready |=> valid_s1)
		else $error("stalled request left the input stage");

	// an empty input stage always takes a request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input stage not ready");

endmodule

// ----- tb/staircase_light_sequencer_core_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the staircase light sequencer core
module staircase_light_sequencer_core_test;
	import slsc_pkg::*;

	localparam int unsigned STAIR_MAX     = 64;
	localparam int unsigned HALF_PERIOD   = 6;
	localparam int unsigned RESET_CYCLES  = 10;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned STUCK_LIMIT   = 2000;
	localparam int unsigned LONG_STALL    = 300;
	localparam int unsigned RANDOM_ITEMS  = 1000;
	localparam int unsigned REPORT_CAP    = 100;

	// register slots that hold nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_UP         = 3'd1,
		PH_DOWN       = 3'd2,
		PH_CLEAR_UP   = 3'd3,
		PH_CLEAR_DOWN = 3'd4
	} stair_phase_e;

	typedef enum logic [0:0] {
		ROW_TICK = 1'b0,
		ROW_REG  = 1'b1
	} row_kind_e;

	// one line of the directed script
	typedef struct packed {
		row_kind_e             kind;
		logic                  top;
		logic                  bottom;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  typed;
		logic                  typed_has;
		slsc_out_t             typed_write;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	slsc_in_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	slsc_out_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow registers and sequencer state of the predictor
	logic [CHAN_W-1:0]  shadow_steps;
	logic [TICK_W-1:0]  shadow_rearm;
	logic [TICK_W-1:0]  shadow_hold;
	logic [TICK_W-1:0]  shadow_light_pace;
	logic [TICK_W-1:0]  shadow_clear_pace;
	logic [LEVEL_W-1:0] shadow_on_level;
	stair_phase_e       stair_phase;
	logic [CHAN_W-1:0]  up_idx;
	logic [CHAN_W-1:0]  down_idx;
	logic [TICK_W-1:0]  since_trig;
	logic [TICK_W-1:0]  since_step;
	logic [TICK_W-1:0]  since_hold;

	slsc_out_t   writes_due[$];
	stim_row_t   script[$];
	int unsigned mismatches;
	int unsigned stuck_cycles;
	int unsigned burst_left;
	bit          bursty;
	bit          stall_req;
	bit          check_typed;
	bit          typed_has;
	slsc_out_t   typed_write;

	staircase_light_sequencer_core #(
		.MAX_STEPS(STAIR_MAX)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// effective step count, clamped to the supported range
	function automatic logic [CHAN_W-1:0] live_steps();
		if (shadow_steps < 1) return 7'd1;
		if (shadow_steps > STAIR_MAX) return 7'(STAIR_MAX);
		return shadow_steps;
	endfunction

	function automatic logic [TICK_W-1:0] sat_inc(logic [TICK_W-1:0] c);
		return (c == TICK_SAT) ? c : c + 16'd1;
	endfunction

	function automatic bit on_stair(logic [CHAN_W-1:0] idx);
		return (idx >= 1) && (idx <= live_steps());
	endfunction

	function automatic void stair_reset();
		shadow_steps      = RST_STEPS_IN_USE;
		shadow_rearm      = RST_REARM_TICKS;
		shadow_hold       = RST_HOLD_TICKS;
		shadow_light_pace = RST_LIGHT_PACE;
		shadow_clear_pace = RST_CLEAR_PACE;
		shadow_on_level   = RST_ON_LEVEL;
		stair_phase       = PH_IDLE;
		up_idx            = 7'd1;
		down_idx          = live_steps();
		since_trig        = '0;
		since_step        = '0;
		since_hold        = '0;
	endfunction

	function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_STEPS_IN_USE: shadow_steps = data[CHAN_W-1:0];
			REG_REARM_TICKS:  shadow_rearm = data;
			REG_HOLD_TICKS:   shadow_hold = data;
			REG_LIGHT_PACE:   shadow_light_pace = data;
			REG_CLEAR_PACE:   shadow_clear_pace = data;
			REG_ON_LEVEL:     shadow_on_level = data[LEVEL_W-1:0];
			default: ;
		endcase
	endfunction

	// one millisecond tick; returns 1 when a channel write comes out
	function automatic bit stair_tick(input slsc_in_t req, output slsc_out_t w);
		logic [CHAN_W-1:0] n;
		bit wrote;
		bit has;
		bit blocked;
		n = live_steps();
		wrote = 0;
		has = 0;
		blocked = 0;
		w = '0;
		since_trig = sat_inc(since_trig);
		since_step = sat_inc(since_step);
		since_hold = sat_inc(since_hold);

		// sensors, top first; a rate-limited top also masks the bottom
		if (req.top_sensor) begin
			if (since_trig < shadow_rearm) begin
				blocked = 1;
			end else begin
				since_trig = '0;
				since_hold = '0;
				if (stair_phase != PH_DOWN) stair_phase = PH_UP;
			end
		end
		if (!blocked && req.bottom_sensor && since_trig >= shadow_rearm) begin
			since_trig = '0;
			since_hold = '0;
			if (stair_phase != PH_UP) stair_phase = PH_DOWN;
		end

		// lighting
		if (stair_phase == PH_UP && up_idx <= n && since_step >= shadow_light_pace) begin
			has = on_stair(up_idx);
			w.channel = up_idx;
			w.level = shadow_on_level;
			wrote = 1;
			since_step = '0;
			up_idx++;
			if (up_idx > n) since_hold = '0;
		end else if (stair_phase == PH_DOWN && down_idx != 0 &&
				since_step >= shadow_light_pace) begin
			has = on_stair(down_idx);
			w.channel = down_idx;
			w.level = shadow_on_level;
			wrote = 1;
			since_step = '0;
			down_idx--;
			if (down_idx == 0) since_hold = '0;
		end

		// hold before clearing
		if (stair_phase == PH_UP && up_idx > n) begin
			if (since_hold >= shadow_hold) stair_phase = PH_CLEAR_UP;
		end else if (stair_phase == PH_DOWN && down_idx == 0) begin
			if (since_hold >= shadow_hold) stair_phase = PH_CLEAR_DOWN;
		end

		// clearing, only in a tick without a lighting write
		if (!wrote && since_step >= shadow_clear_pace) begin
			if (stair_phase == PH_CLEAR_UP) begin
				has = on_stair(up_idx);
				w.channel = up_idx;
				w.level = '0;
				if (up_idx != 0) up_idx--;
				since_step = '0;
				if (up_idx == 0) begin
					stair_phase = PH_IDLE;
					up_idx = 7'd1;
				end
			end else if (stair_phase == PH_CLEAR_DOWN) begin
				has = on_stair(down_idx);
				w.channel = down_idx;
				w.level = '0;
				down_idx++;
				since_step = '0;
				if (down_idx > n) begin
					stair_phase = PH_IDLE;
					down_idx = n;
				end
			end
		end
		return has;
	endfunction

	// script builders
	function automatic void add_tick(logic top, logic bottom);
		stim_row_t r;
		r = '0;
		r.kind = ROW_TICK;
		r.top = top;
		r.bottom = bottom;
		script.push_back(r);
	endfunction

	function automatic void add_typed(logic top, logic bottom, logic has,
			logic [CHAN_W-1:0] ch, logic [LEVEL_W-1:0] lvl);
		stim_row_t r;
		r = '0;
		r.kind = ROW_TICK;
		r.top = top;
		r.bottom = bottom;
		r.typed = 1'b1;
		r.typed_has = has;
		r.typed_write.channel = ch;
		r.typed_write.level = lvl;
		script.push_back(r);
	endfunction

	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = data;
		script.push_back(r);
	endfunction

	// offer one tick request and wait for it, then maybe leave a gap
	task automatic offer_tick(logic top, logic bottom);
		slsc_in_t req;
		req.top_sensor = top;
		req.bottom_sensor = bottom;
		in_data <= req;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		if (bursty) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				burst_left = $urandom_range(0, 40);
			end else begin
				burst_left--;
			end
		end
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// stop sending, wait for every expected write, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (writes_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_random_setup();
		logic [CFG_DATA_W-1:0] word;
		if ($urandom_range(0, 3) != 0) begin
			word = 16'($urandom);
			case ($urandom_range(0, 9))
				0: word[CHAN_W-1:0] = 7'd0;
				1: word[CHAN_W-1:0] = 7'd64;
				2: word[CHAN_W-1:0] = 7'd127;
				default: word[CHAN_W-1:0] = 7'($urandom_range(1, 8));
			endcase
			write_reg(REG_STEPS_IN_USE, word);
		end
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_REARM_TICKS, ($urandom_range(0, 9) == 0) ?
				16'($urandom_range(0, 60)) : 16'($urandom_range(0, 3)));
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_HOLD_TICKS, ($urandom_range(0, 9) == 0) ?
				16'($urandom_range(20, 80)) : 16'($urandom_range(0, 5)));
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_LIGHT_PACE, 16'($urandom_range(0, 4)));
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_CLEAR_PACE, 16'($urandom_range(0, 4)));
		if ($urandom_range(0, 3) != 0)
			write_reg(REG_ON_LEVEL, 16'($urandom));
		if ($urandom_range(0, 7) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// receiver: segments of steady, random and sparse ready, plus one long hold-off
	initial begin
		int unsigned seg_left;
		int unsigned seg_mode;
		seg_left = 0;
		seg_mode = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				out_ready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				stall_req = 0;
				out_ready <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_mode = $urandom_range(0, 2);
					seg_left = $urandom_range(10, 150);
				end
				seg_left--;
				case (seg_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= (seg_left % 4 == 0);
				endcase
			end
		end
	end

	// compare writes, track register writes, predict each accepted tick
	always @(posedge clk) begin
		slsc_out_t due;
		slsc_out_t next_write;
		bit has_write;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (writes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display("%0t: unexpected channel write, channel %0d level %0d",
							$time, out_data.channel, out_data.level);
				end else begin
					due = writes_due.pop_front();
					if (out_data.channel !== due.channel) begin
						mismatches++;
						if (mismatches <= REPORT_CAP)
							$display("%0t: channel mismatch, expected %0d, got %0d",
								$time, due.channel, out_data.channel);
					end
					if (out_data.level !== due.level) begin
						mismatches++;
						if (mismatches <= REPORT_CAP)
							$display("%0t: level mismatch on channel %0d, expected %0d, got %0d",
								$time, due.channel, due.level, out_data.level);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				shadow_write(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				has_write = stair_tick(in_data, next_write);
				if (check_typed) begin
					has_write = typed_has;
					next_write = typed_write;
				end
				if (has_write) writes_due.push_back(next_write);
			end
		end
	end

	// watchdog on cycles without any request moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, STUCK_LIMIT);
			$display("staircase_light_sequencer_core_test NOT OK");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		bit cfg_open;
		int unsigned random_items;
		int unsigned phase_no;
		int unsigned count;
		int unsigned trig_pct;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_STEPS_IN_USE;
		cfg_data = '0;
		mismatches = 0;
		stuck_cycles = 0;
		burst_left = 0;
		bursty = 1;
		stall_req = 0;
		check_typed = 0;
		typed_has = 0;
		typed_write = '0;
		cfg_open = 0;
		random_items = 0;
		phase_no = 0;
		stair_reset();

		// directed script
		// defaults after reset: every trigger is still rate limited
		add_typed(1'b0, 1'b0, 1'b0, 7'd0, 8'd0);
		add_typed(1'b1, 1'b1, 1'b0, 7'd0, 8'd0);
		add_typed(1'b1, 1'b0, 1'b0, 7'd0, 8'd0);
		// three fast steps, short hold
		add_reg(REG_STEPS_IN_USE, 16'd3);
		add_reg(REG_REARM_TICKS, 16'd0);
		add_reg(REG_LIGHT_PACE, 16'd0);
		add_reg(REG_CLEAR_PACE, 16'd0);
		add_reg(REG_HOLD_TICKS, 16'd1);
		add_reg(REG_ON_LEVEL, 16'h00FF);
		add_reg(REG_SPARE_6, 16'hFFFF);
		add_reg(REG_SPARE_7, 16'hFFFF);
		add_typed(1'b1, 1'b0, 1'b1, 7'd1, 8'd255);
		add_tick(1'b0, 1'b0);
		// bottom trigger while lighting up restarts the hold only
		add_tick(1'b0, 1'b1);
		add_tick(1'b0, 1'b0);
		// first clearing slot lies past the top end
		add_tick(1'b0, 1'b0);
		add_tick(1'b0, 1'b0);
		// retrigger while clearing resumes lighting
		add_tick(1'b1, 1'b0);
		add_tick(1'b0, 1'b0);
		add_tick(1'b0, 1'b0);
		add_tick(1'b0, 1'b0);
		// zero steps clamps to one, zero hold defers the clear, level off
		add_reg(REG_STEPS_IN_USE, 16'hFF80);
		add_reg(REG_HOLD_TICKS, 16'd0);
		add_reg(REG_ON_LEVEL, 16'hFF00);
		add_tick(1'b0, 1'b1);
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b1);
		add_tick(1'b0, 1'b0);
		// all-ones registers, step count above the maximum
		add_reg(REG_STEPS_IN_USE, 16'h007F);
		add_reg(REG_REARM_TICKS, 16'hFFFF);
		add_reg(REG_HOLD_TICKS, 16'hFFFF);
		add_reg(REG_LIGHT_PACE, 16'hFFFF);
		add_reg(REG_CLEAR_PACE, 16'hFFFF);
		add_reg(REG_ON_LEVEL, 16'h00AB);
		add_tick(1'b1, 1'b1);
		add_tick(1'b0, 1'b1);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_REG) begin
				if (!cfg_open) settle();
				write_reg(row.idx, row.data);
				cfg_open = 1;
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 0;
				end
				check_typed = row.typed;
				typed_has = row.typed_has;
				typed_write = row.typed_write;
				offer_tick(row.top, row.bottom);
				check_typed = 0;
			end
		end

		// random phases, one with the receiver held off while triggers keep coming
		while (random_items < RANDOM_ITEMS) begin
			settle();
			if (phase_no == 2) begin
				write_reg(REG_STEPS_IN_USE, {9'($urandom), 7'd64});
				write_reg(REG_REARM_TICKS, 16'd0);
				write_reg(REG_LIGHT_PACE, 16'd0);
				write_reg(REG_CLEAR_PACE, 16'd0);
				write_reg(REG_HOLD_TICKS, 16'd0);
				cfg_valid <= 1'b0;
				bursty = 0;
				stall_req = 1;
				count = 150;
				repeat (count)
					offer_tick($urandom_range(0, 99) < 50, $urandom_range(0, 99) < 30);
				bursty = 1;
			end else begin
				program_random_setup();
				trig_pct = $urandom_range(3, 30);
				count = $urandom_range(60, 140);
				repeat (count)
					offer_tick($urandom_range(0, 99) < trig_pct,
						$urandom_range(0, 99) < trig_pct);
			end
			random_items += count;
			phase_no++;
		end

		settle();
		if (mismatches == 0 && writes_due.size() == 0) begin
			$display("staircase_light_sequencer_core_test OK");
		end else begin
			$display("staircase_light_sequencer_core_test NOT OK");
		end
		$finish;
	end

endmodule
